// ===== design/assert_macros.svh =====
// Assertion macros shared by the I2C EEPROM page access master RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds on every rising clock edge outside reset.
`define IEPAM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion lbl failed");

// Checks that a condition never holds outside reset.
`define IEPAM_NEVER(lbl, clk, rst_n, cond) \
  `IEPAM_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ===== design/iepam_pkg.sv =====
// Shared types and constants of the I2C EEPROM page access master.
// No dependencies; imported by every module of the block.
`default_nettype none

package iepam_pkg;

  localparam int unsigned PageBytes = 128;
  localparam int unsigned PageBits  = $clog2(PageBytes);

  localparam logic [6:0]  DevAddrReset  = 7'd80;
  localparam logic [15:0] HalfReset     = 16'd500;
  localparam logic [23:0] WaitReset     = 24'd500000;

  typedef enum logic [1:0] {
    CFG_DEV_ADDR = 2'd0,
    CFG_HALF     = 2'd1,
    CFG_WAIT     = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_WB_LO, PH_WB_HI, PH_WA_LO,
    PH_WA_HI, PH_WA_TAIL, PH_DATA_WAIT, PH_RB_LO, PH_RB_HI, PH_RA_LO,
    PH_RA_HI, PH_RA_TAIL, PH_SP_A, PH_SP_B, PH_SP_C, PH_WAIT
  } phase_e;

  typedef enum logic [2:0] {
    STEP_DEVW, STEP_ADDRH, STEP_ADDRL, STEP_DATA, STEP_DEVR
  } step_e;

  typedef struct packed {
    logic        start_req;
    logic        mode;
    logic [15:0] start_address;
    logic [15:0] byte_count;
    logic [7:0]  write_data;
    logic        write_data_valid;
    logic        sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       write_data_taken;
    logic [7:0] read_data;
    logic       read_data_valid;
    logic       ack_error;
    logic       done_res;
  } res_t;

  typedef struct packed {
    logic [6:0]  dev_addr;
    logic [15:0] half_ticks;
    logic [23:0] wait_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/iepam_in_q.sv =====
// Two-entry input queue that accepts ticks on the front side.
// Depends on iepam_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module iepam_in_q (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire iepam_pkg::tick_t push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output iepam_pkg::tick_t      pop_data_o
);
  import iepam_pkg::*;

  tick_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `IEPAM_ASSERT(a_in_count_range, clk_i, rst_ni, count_q != 2'd3)
  `IEPAM_ASSERT(a_in_blocked_push, clk_i, rst_ni,
                (push_i && full_o && !pop_i) |=> (count_q == $past(count_q)))

endmodule

`default_nettype wire

// ===== design/iepam_engine.sv =====
// Back part: the I2C line sequencer, advanced once per queued tick.
// Depends on iepam_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module iepam_engine (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire iepam_pkg::cfg_t  cfg_i,
  input  wire logic             fire_i,
  input  wire iepam_pkg::tick_t tick_i,
  output iepam_pkg::res_t       res_o
);
  import iepam_pkg::*;

  phase_e      phase_q, phase_d;
  step_e       step_q, step_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] left_q, left_d;
  logic [23:0] tc_q, tc_d;
  logic        nack_q, nack_d;
  logic        rmode_q, rmode_d;

  logic [15:0] half_eff;
  logic [23:0] tc_inc, seg_tc;
  logic        seg;
  logic [15:0] addr_inc, left_dec;
  logic [7:0]  rx_byte;

  always_comb begin
    half_eff = (cfg_i.half_ticks == 16'd0) ? 16'd1 : cfg_i.half_ticks;
    tc_inc   = tc_q + 24'd1;
    seg      = (tc_inc >= {8'd0, half_eff});
    seg_tc   = seg ? 24'd0 : tc_inc;
    addr_inc = addr_q + 16'd1;
    left_dec = (left_q != 16'd0) ? (left_q - 16'd1) : 16'd0;
    rx_byte  = {shift_q[6:0], tick_i.sda_in};

    phase_d = phase_q;
    step_d  = step_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    addr_d  = addr_q;
    left_d  = left_q;
    tc_d    = tc_q;
    nack_d  = nack_q;
    rmode_d = rmode_q;

    res_o                  = '0;
    res_o.scl_out          = 1'b1;
    res_o.sda_out          = 1'b1;
    res_o.busy_res         = (phase_q != PH_IDLE);

    unique case (phase_q)
      PH_IDLE: begin
        if (tick_i.start_req) begin
          nack_d  = 1'b0;
          rmode_d = tick_i.mode;
          addr_d  = tick_i.start_address;
          left_d  = tick_i.byte_count;
          tc_d    = 24'd0;
          if (tick_i.byte_count == 16'd0) begin
            res_o.done_res = 1'b1;
          end else begin
            step_d  = STEP_DEVW;
            phase_d = PH_ST_A;
          end
        end
      end
      PH_ST_A: begin
        res_o.scl_out = 1'b0;
        tc_d = seg_tc;
        if (seg) phase_d = PH_ST_B;
      end
      PH_ST_B: begin
        tc_d = seg_tc;
        if (seg) phase_d = PH_ST_C;
      end
      PH_ST_C: begin
        res_o.sda_out = 1'b0;
        tc_d = seg_tc;
        if (seg) begin
          shift_d = {cfg_i.dev_addr, (step_q == STEP_DEVR)};
          bit_d   = 4'd0;
          phase_d = PH_WB_LO;
        end
      end
      PH_WB_LO: begin
        res_o.scl_out = 1'b0;
        res_o.sda_out = shift_q[7];
        tc_d = seg_tc;
        if (seg) phase_d = PH_WB_HI;
      end
      PH_WB_HI: begin
        res_o.sda_out = shift_q[7];
        tc_d = seg_tc;
        if (seg) begin
          shift_d = {shift_q[6:0], 1'b0};
          bit_d   = bit_q + 4'd1;
          phase_d = (bit_q == 4'd7) ? PH_WA_LO : PH_WB_LO;
        end
      end
      PH_WA_LO: begin
        res_o.scl_out = 1'b0;
        tc_d = seg_tc;
        if (seg) phase_d = PH_WA_HI;
      end
      PH_WA_HI: begin
        tc_d = seg_tc;
        if (seg) begin
          if (tick_i.sda_in) nack_d = 1'b1;
          phase_d = PH_WA_TAIL;
        end
      end
      PH_WA_TAIL: begin
        res_o.scl_out = 1'b0;
        tc_d = seg_tc;
        if (seg) begin
          case (step_q)
            STEP_DEVW: begin
              step_d  = STEP_ADDRH;
              shift_d = addr_q[15:8];
              bit_d   = 4'd0;
              phase_d = PH_WB_LO;
            end
            STEP_ADDRH: begin
              step_d  = STEP_ADDRL;
              shift_d = addr_q[7:0];
              bit_d   = 4'd0;
              phase_d = PH_WB_LO;
            end
            STEP_ADDRL: begin
              if (rmode_q) begin
                step_d  = STEP_DEVR;
                phase_d = PH_ST_A;
              end else begin
                step_d  = STEP_DATA;
                phase_d = PH_DATA_WAIT;
              end
            end
            STEP_DATA: begin
              addr_d = addr_inc;
              left_d = left_dec;
              // The burst ends on its last byte or when the address crosses a page boundary.
              if (left_dec == 16'd0 || addr_inc[PageBits-1:0] == '0) begin
                phase_d = PH_SP_A;
              end else begin
                phase_d = PH_DATA_WAIT;
              end
            end
            default: begin
              shift_d = 8'd0;
              bit_d   = 4'd0;
              phase_d = PH_RB_LO;
            end
          endcase
        end
      end
      PH_DATA_WAIT: begin
        res_o.scl_out = 1'b0;
        if (tick_i.write_data_valid) begin
          res_o.write_data_taken = 1'b1;
          tc_d    = 24'd0;
          shift_d = tick_i.write_data;
          bit_d   = 4'd0;
          phase_d = PH_WB_LO;
        end
      end
      PH_RB_LO: begin
        res_o.scl_out = 1'b0;
        tc_d = seg_tc;
        if (seg) phase_d = PH_RB_HI;
      end
      PH_RB_HI: begin
        tc_d = seg_tc;
        if (seg) begin
          shift_d = rx_byte;
          bit_d   = bit_q + 4'd1;
          if (bit_q == 4'd7) begin
            res_o.read_data_valid = 1'b1;
            res_o.read_data       = rx_byte;
            left_d  = left_dec;
            addr_d  = addr_inc;
            phase_d = PH_RA_LO;
          end else begin
            phase_d = PH_RB_LO;
          end
        end
      end
      PH_RA_LO, PH_RA_HI, PH_RA_TAIL: begin
        res_o.scl_out = (phase_q == PH_RA_HI);
        res_o.sda_out = (left_q == 16'd0);
        tc_d = seg_tc;
        if (seg) begin
          if (phase_q == PH_RA_LO) begin
            phase_d = PH_RA_HI;
          end else if (phase_q == PH_RA_HI) begin
            phase_d = PH_RA_TAIL;
          end else if (left_q == 16'd0) begin
            phase_d = PH_SP_A;
          end else begin
            shift_d = 8'd0;
            bit_d   = 4'd0;
            phase_d = PH_RB_LO;
          end
        end
      end
      PH_SP_A: begin
        res_o.scl_out = 1'b0;
        res_o.sda_out = 1'b0;
        tc_d = seg_tc;
        if (seg) phase_d = PH_SP_B;
      end
      PH_SP_B: begin
        res_o.sda_out = 1'b0;
        tc_d = seg_tc;
        if (seg) phase_d = PH_SP_C;
      end
      PH_SP_C, PH_WAIT: begin
        // Both the end of the stop and the write-cycle wait may finish the page.
        tc_d = (phase_q == PH_SP_C) ? seg_tc : tc_inc;
        if ((phase_q == PH_SP_C && seg && cfg_i.wait_ticks == 24'd0) ||
            (phase_q == PH_WAIT && tc_inc >= cfg_i.wait_ticks)) begin
          tc_d = 24'd0;
          if (!rmode_q && left_q != 16'd0) begin
            step_d  = STEP_DEVW;
            phase_d = PH_ST_A;
          end else begin
            phase_d        = PH_IDLE;
            res_o.done_res = 1'b1;
          end
        end else if (phase_q == PH_SP_C && seg) begin
          phase_d = PH_WAIT;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tc_d    = 24'd0;
      end
    endcase

    res_o.ack_error = nack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= STEP_DEVW;
      bit_q   <= 4'd0;
      shift_q <= 8'd0;
      addr_q  <= 16'd0;
      left_q  <= 16'd0;
      tc_q    <= 24'd0;
      nack_q  <= 1'b0;
      rmode_q <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      addr_q  <= addr_d;
      left_q  <= left_d;
      tc_q    <= tc_d;
      nack_q  <= nack_d;
      rmode_q <= rmode_d;
    end
  end

  `IEPAM_NEVER(a_taken_and_done, clk_i, rst_ni,
               fire_i && res_o.write_data_taken && res_o.done_res)
  `IEPAM_ASSERT(a_taken_sends, clk_i, rst_ni,
                (fire_i && res_o.write_data_taken) |=> (phase_q == PH_WB_LO))

endmodule

`default_nettype wire

// ===== design/iepam_out_q.sv =====
// Two-entry result queue that parts the engine from the result consumer.
// Depends on iepam_pkg.
`default_nettype none

module iepam_out_q (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire iepam_pkg::res_t push_data_i,
  output logic                 space_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output iepam_pkg::res_t      pop_data_o
);
  import iepam_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign space_o    = (count_q != 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && space_o;
  assign do_pop     = pop_i && !empty_o;
  assign count_d    = count_q + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q ^ do_push;
      rd_ptr_q <= rd_ptr_q ^ do_pop;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/i2c_eeprom_page_access_master_core.sv =====
// Top level of the I2C EEPROM page access master.
// Depends on iepam_pkg, iepam_in_q, iepam_engine and iepam_out_q.
`default_nettype none

// Channel   Handshake                  Contents
// input     push / full                one clock tick of host and SDA inputs
// result    pop / empty                SCL, SDA and status produced by that tick
// config    cfg_valid_i / cfg_ready_o  register index and write data
//
// Every queued tick is processed by the line sequencer as it leaves the input queue, so
// the block sustains one item per cycle while the result queue has room; each tick is registered in both queues.
// A two-entry queue on each side lets either neighbor stall without losing items.
// Reset clears both queues and the sequencer and loads the register defaults.
// Configuration writes are always accepted and take effect on the next cycle.

module i2c_eeprom_page_access_master_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        start_req_i,
  input  wire logic        mode_i,
  input  wire logic [15:0] start_address_i,
  input  wire logic [15:0] byte_count_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic        write_data_valid_i,
  input  wire logic        sda_in_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             scl_out_o,
  output logic             sda_out_o,
  output logic             busy_res_o,
  output logic             write_data_taken_o,
  output logic [7:0]       read_data_o,
  output logic             read_data_valid_o,
  output logic             ack_error_o,
  output logic             done_res_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);
  import iepam_pkg::*;

  tick_t    tick_in, tick_q;
  res_t     res, res_out;
  cfg_t     cfg_q;
  logic     tick_valid, out_space, fire;
  cfg_idx_e cfg_idx;

  assign tick_in = '{start_req: start_req_i, mode: mode_i,
                     start_address: start_address_i, byte_count: byte_count_i,
                     write_data: write_data_i, write_data_valid: write_data_valid_i,
                     sda_in: sda_in_i};

  // The engine advances whenever a tick is queued and its result has room.
  assign fire        = tick_valid && out_space;
  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = cfg_idx_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{dev_addr: DevAddrReset, half_ticks: HalfReset, wait_ticks: WaitReset};
    end else if (cfg_valid_i) begin
      unique case (cfg_idx)
        CFG_DEV_ADDR: cfg_q.dev_addr   <= cfg_data_i[6:0];
        CFG_HALF:     cfg_q.half_ticks <= cfg_data_i[15:0];
        CFG_WAIT:     cfg_q.wait_ticks <= cfg_data_i;
        default:      cfg_q            <= cfg_q;
      endcase
    end
  end

  iepam_in_q u_in_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (tick_in),
    .full_o      (full),
    .pop_i       (fire),
    .valid_o     (tick_valid),
    .pop_data_o  (tick_q)
  );

  iepam_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .fire_i (fire),
    .tick_i (tick_q),
    .res_o  (res)
  );

  iepam_out_q u_out_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .push_data_i (res),
    .space_o     (out_space),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (res_out)
  );

  assign scl_out_o          = res_out.scl_out;
  assign sda_out_o          = res_out.sda_out;
  assign busy_res_o         = res_out.busy_res;
  assign write_data_taken_o = res_out.write_data_taken;
  assign read_data_o        = res_out.read_data;
  assign read_data_valid_o  = res_out.read_data_valid;
  assign ack_error_o        = res_out.ack_error;
  assign done_res_o         = res_out.done_res;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the I2C EEPROM page access master core.
// Depends on iepam_pkg and the core RTL; one queued tick per input item.
`timescale 1ns / 100ps

module tb;
  import iepam_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        start_req_i = 1'b0;
  logic        mode_i = 1'b0;
  logic [15:0] start_address_i = '0;
  logic [15:0] byte_count_i = '0;
  logic [7:0]  write_data_i = '0;
  logic        write_data_valid_i = 1'b0;
  logic        sda_in_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        scl_out_o, sda_out_o, busy_res_o, write_data_taken_o;
  logic [7:0]  read_data_o;
  logic        read_data_valid_o, ack_error_o, done_res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_e    cfg_index_i = CFG_DEV_ADDR;
  logic [23:0] cfg_data_i = '0;

  i2c_eeprom_page_access_master_core dut (
    .clk_i, .rst_ni, .push, .full, .start_req_i, .mode_i, .start_address_i,
    .byte_count_i, .write_data_i, .write_data_valid_i, .sda_in_i, .empty, .pop,
    .scl_out_o, .sda_out_o, .busy_res_o, .write_data_taken_o, .read_data_o,
    .read_data_valid_o, .ack_error_o, .done_res_o, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Ticks waiting to be pushed, and line states expected back, oldest first.
  tick_t tick_q[$];
  res_t  line_q[$];
  int    errors = 0;
  bit    hold = 1'b0;  // keeps the driver from pushing
  bit    calm = 1'b0;  // no idling on either side once set

  // Shadow copy of the sequencer state and its registers.
  logic [6:0]  m_dev = DevAddrReset;
  logic [15:0] m_half = HalfReset;
  logic [23:0] m_wait = WaitReset;
  phase_e      m_ph = PH_IDLE;
  step_e       m_step = STEP_DEVW;
  logic [3:0]  m_bit = '0;
  logic [7:0]  m_shift = '0;
  logic [15:0] m_addr = '0;
  logic [15:0] m_left = '0;
  logic [23:0] m_cnt = '0;
  logic        m_nack = 1'b0;
  logic        m_rd = 1'b0;

  // Counts one tick of the current half period; true when it has elapsed.
  function automatic bit half_elapsed();
    logic [23:0] h;
    h = (m_half == 16'd0) ? 24'd1 : {8'd0, m_half};
    m_cnt = m_cnt + 24'd1;
    if (m_cnt >= h) begin
      m_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void load_byte(logic [7:0] b);
    m_shift = b;
    m_bit = '0;
    m_ph = PH_WB_LO;
  endfunction

  // Moves the header or data sequence on once a written byte's ack slot ends.
  function automatic void next_after_ack();
    case (m_step)
      STEP_DEVW: begin
        m_step = STEP_ADDRH;
        load_byte(m_addr[15:8]);
      end
      STEP_ADDRH: begin
        m_step = STEP_ADDRL;
        load_byte(m_addr[7:0]);
      end
      STEP_ADDRL: begin
        if (m_rd) begin
          m_step = STEP_DEVR;
          m_ph = PH_ST_A;
        end else begin
          m_step = STEP_DATA;
          m_ph = PH_DATA_WAIT;
        end
      end
      STEP_DATA: begin
        m_addr = m_addr + 16'd1;
        if (m_left != 16'd0) m_left = m_left - 16'd1;
        // A page boundary ends the burst; the rest goes in a new one.
        if (m_left == 16'd0 || m_addr[PageBits-1:0] == '0) m_ph = PH_SP_A;
        else m_ph = PH_DATA_WAIT;
      end
      default: begin
        m_shift = '0;
        m_bit = '0;
        m_ph = PH_RB_LO;
      end
    endcase
  endfunction

  // Returns 1 when the write cycle wait closes the whole transaction.
  function automatic bit wait_over();
    m_cnt = '0;
    if (!m_rd && m_left != 16'd0) begin
      m_step = STEP_DEVW;
      m_ph = PH_ST_A;
      return 1'b0;
    end
    m_ph = PH_IDLE;
    return 1'b1;
  endfunction

  // Advances the shadow sequencer by one tick and returns its line state.
  function automatic res_t line_state(tick_t t);
    res_t r;
    r = '0;
    r.scl_out = 1'b1;
    r.sda_out = 1'b1;
    r.busy_res = (m_ph != PH_IDLE);
    case (m_ph)
      PH_IDLE: if (t.start_req) begin
        m_nack = 1'b0;
        m_rd = t.mode;
        m_addr = t.start_address;
        m_left = t.byte_count;
        m_cnt = '0;
        if (t.byte_count == 16'd0) r.done_res = 1'b1;
        else begin
          m_step = STEP_DEVW;
          m_ph = PH_ST_A;
        end
      end
      PH_ST_A: begin
        r.scl_out = 1'b0;
        if (half_elapsed()) m_ph = PH_ST_B;
      end
      PH_ST_B: if (half_elapsed()) m_ph = PH_ST_C;
      PH_ST_C: begin
        r.sda_out = 1'b0;
        if (half_elapsed()) load_byte({m_dev, m_step == STEP_DEVR});
      end
      PH_WB_LO: begin
        r.scl_out = 1'b0;
        r.sda_out = m_shift[7];
        if (half_elapsed()) m_ph = PH_WB_HI;
      end
      PH_WB_HI: begin
        r.sda_out = m_shift[7];
        if (half_elapsed()) begin
          m_shift = {m_shift[6:0], 1'b0};
          m_bit = m_bit + 4'd1;
          m_ph = (m_bit >= 4'd8) ? PH_WA_LO : PH_WB_LO;
        end
      end
      PH_WA_LO: begin
        r.scl_out = 1'b0;
        if (half_elapsed()) m_ph = PH_WA_HI;
      end
      PH_WA_HI: if (half_elapsed()) begin
        if (t.sda_in) m_nack = 1'b1;
        m_ph = PH_WA_TAIL;
      end
      PH_WA_TAIL: begin
        r.scl_out = 1'b0;
        if (half_elapsed()) next_after_ack();
      end
      PH_DATA_WAIT: begin
        // SCL is held low until the host offers a byte.
        r.scl_out = 1'b0;
        if (t.write_data_valid) begin
          r.write_data_taken = 1'b1;
          m_cnt = '0;
          load_byte(t.write_data);
        end
      end
      PH_RB_LO: begin
        r.scl_out = 1'b0;
        if (half_elapsed()) m_ph = PH_RB_HI;
      end
      PH_RB_HI: if (half_elapsed()) begin
        m_shift = {m_shift[6:0], t.sda_in};
        m_bit = m_bit + 4'd1;
        if (m_bit >= 4'd8) begin
          r.read_data_valid = 1'b1;
          r.read_data = m_shift;
          if (m_left != 16'd0) m_left = m_left - 16'd1;
          m_addr = m_addr + 16'd1;
          m_ph = PH_RA_LO;
        end else m_ph = PH_RB_LO;
      end
      PH_RA_LO, PH_RA_HI, PH_RA_TAIL: begin
        // The last byte of a read is NACKed, all others ACKed.
        r.scl_out = (m_ph == PH_RA_HI);
        r.sda_out = (m_left == 16'd0);
        if (half_elapsed()) begin
          if (m_ph == PH_RA_LO) m_ph = PH_RA_HI;
          else if (m_ph == PH_RA_HI) m_ph = PH_RA_TAIL;
          else if (m_left == 16'd0) m_ph = PH_SP_A;
          else begin
            m_shift = '0;
            m_bit = '0;
            m_ph = PH_RB_LO;
          end
        end
      end
      PH_SP_A: begin
        r.scl_out = 1'b0;
        r.sda_out = 1'b0;
        if (half_elapsed()) m_ph = PH_SP_B;
      end
      PH_SP_B: begin
        r.sda_out = 1'b0;
        if (half_elapsed()) m_ph = PH_SP_C;
      end
      PH_SP_C: if (half_elapsed()) begin
        if (m_wait == 24'd0) r.done_res = wait_over();
        else m_ph = PH_WAIT;
      end
      PH_WAIT: begin
        m_cnt = m_cnt + 24'd1;
        if (m_cnt >= m_wait) r.done_res = wait_over();
      end
      default: begin
        m_ph = PH_IDLE;
        m_cnt = '0;
      end
    endcase
    r.ack_error = m_nack;
    return r;
  endfunction

  // Driver: presents queued ticks, with random idle bursts between them.
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    tick_t t;
    if (!rst_ni) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) begin
        t = '{start_req_i, mode_i, start_address_i, byte_count_i, write_data_i,
              write_data_valid_i, sda_in_i};
        line_q.push_back(line_state(t));
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (hold || tick_q.size() == 0) begin
          push <= 1'b0;
        end else begin
          t = tick_q.pop_front();
          start_req_i        <= t.start_req;
          mode_i             <= t.mode;
          start_address_i    <= t.start_address;
          byte_count_i       <= t.byte_count;
          write_data_i       <= t.write_data;
          write_data_valid_i <= t.write_data_valid;
          sda_in_i           <= t.sda_in;
          push <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
        end
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Monitor: pops results with random stalls and checks each field in order.
  int pop_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      pop <= 1'b0;
      pop_gap = 0;
    end else begin
      if (pop && !empty) begin
        if (line_q.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          e = line_q.pop_front();
          check_field("scl_out", e.scl_out, scl_out_o);
          check_field("sda_out", e.sda_out, sda_out_o);
          check_field("busy_res", e.busy_res, busy_res_o);
          check_field("write_data_taken", e.write_data_taken, write_data_taken_o);
          check_field("read_data", e.read_data, read_data_o);
          check_field("read_data_valid", e.read_data_valid, read_data_valid_o);
          check_field("ack_error", e.ack_error, ack_error_o);
          check_field("done_res", e.done_res, done_res_o);
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        pop_gap = $urandom_range(0, 15);
        pop <= 1'b0;
      end else pop <= 1'b1;
    end
  end

  task automatic add_tick(bit req, bit md, logic [15:0] sa, logic [15:0] bc,
                          logic [7:0] wd, bit wv, bit sdi);
    tick_q.push_back('{req, md, sa, bc, wd, wv, sdi});
  endtask

  // Blocks until every queued tick was accepted and every result checked.
  task automatic drain();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || push || line_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DEV_ADDR: m_dev = val[6:0];
      CFG_HALF:     m_half = val[15:0];
      CFG_WAIT:     m_wait = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [6:0] dev, logic [15:0] half, logic [23:0] wt);
    write_reg(CFG_DEV_ADDR, {17'd0, dev});
    write_reg(CFG_HALF, {8'd0, half});
    write_reg(CFG_WAIT, wt);
  endtask

  // One transaction request followed by a run of random host and SDA ticks.
  task automatic add_transaction(int ticks);
    logic [15:0] sa;
    sa = $urandom_range(0, 3) == 0 ? 16'h007e + 16'($urandom_range(0, 3)) * 16'h0080
                                   : 16'($urandom);
    add_tick(1'b1, 1'($urandom_range(0, 1)), sa, 16'($urandom_range(0, 5)),
             8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    repeat (ticks) begin
      // Occasional stray requests; small counts keep any accepted one short.
      add_tick($urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)), 16'($urandom),
               16'($urandom_range(0, 7)), 8'($urandom), $urandom_range(0, 3) != 0,
               $urandom_range(0, 4) == 0);
    end
  endtask

  task automatic random_phase(int n);
    int cnt;
    cnt = 0;
    while (cnt < n) begin
      int len;
      len = $urandom_range(30, 160);
      add_transaction(len);
      cnt += len + 1;
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fastest timing, no write wait, bus address zero.
    configure(7'd0, 16'd1, 24'd0);
    // Zero byte count finishes at once without bus activity.
    add_tick(1'b1, 1'b0, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0);
    // Write starting at the top address, so the address wraps to zero.
    add_tick(1'b1, 1'b0, 16'hffff, 16'd2, 8'hff, 1'b1, 1'b0);
    // Requests while busy are ignored; they carry the field extremes.
    for (int i = 0; i < 22; i++)
      add_tick(1'b1, i[0], i[1] ? 16'hffff : 16'h0000, 16'hffff,
               i[0] ? 8'hff : 8'h00, i[0], i[1]);
    drain();

    // The sender is held back while a transaction is queued, then released.
    hold = 1'b1;
    add_transaction(60);
    repeat (20) @(posedge clk_i);
    hold = 1'b0;
    drain();

    configure(7'd127, 16'd2, 24'd5);
    random_phase(180);
    configure(7'd80, 16'd0, 24'd1);
    random_phase(180);
    configure(7'd42, 16'd3, 24'd17);
    random_phase(100);
    configure(7'd127, 16'd65535, 24'd16777215);
    random_phase(40);
    configure(7'd5, 16'd1, 24'd3);
    calm = 1'b1;
    random_phase(100);

    repeat (10) @(posedge clk_i);
    if (errors == 0 && line_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/iepam_pkg.sv
design/iepam_in_q.sv
design/iepam_engine.sv
design/iepam_out_q.sv
design/i2c_eeprom_page_access_master_core.sv
dv/tb.sv
